[rtl/jse_pkg.sv]
// Package: payload types, controller/datapath interface types, scan helpers.
`default_nettype none

package jse_pkg;

    // Input and output payloads
    typedef struct packed {
        logic [7:0] data_byte;
        logic       string_last;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       string_done;
    } t_out;

    // Scan action at the head of the queue
    localparam logic [2:0] K_STOP  = 3'd0;  // nothing to emit now
    localparam logic [2:0] K_PASS  = 3'd1;  // copy len raw bytes
    localparam logic [2:0] K_SHORT = 3'd2;  // backslash plus one letter
    localparam logic [2:0] K_UHEX  = 3'd3;  // \u00 plus two hex digits
    localparam logic [2:0] K_BAD   = 3'd4;  // \ufffd for the lead byte

    localparam logic [7:0] CH_BSL = 8'h5c;
    localparam logic [7:0] CH_QUO = 8'h22;

    typedef struct packed {
        logic [2:0] kind;
        logic [2:0] len;
    } t_plan;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic emit;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic       stop;
        logic       final_byte;
        logic       look_stop;
        logic       out_free;
        logic [2:0] count;
    } t_sts;

    function automatic logic [7:0] f_hex(input logic [3:0] v);
        logic [7:0] r;
        if (v < 4'd10) begin
            r = 8'h30 + {4'd0, v};
        end else begin
            r = 8'h57 + {4'd0, v};
        end
        return r;
    endfunction

    function automatic logic [7:0] f_short_letter(input logic [7:0] b);
        logic [7:0] r;
        unique case (b)
            8'h08:   r = 8'h62;  // b
            8'h0c:   r = 8'h66;  // f
            8'h0a:   r = 8'h6e;  // n
            8'h0d:   r = 8'h72;  // r
            8'h09:   r = 8'h74;  // t
            default: r = b;      // quote and backslash stand as themselves
        endcase
        return r;
    endfunction

    // Decide the action at the head of the queue q0..q3 holding n bytes.
    function automatic t_plan f_classify(input logic [7:0] q0, input logic [7:0] q1,
                                         input logic [7:0] q2, input logic [7:0] q3,
                                         input logic [2:0] n, input logic last);
        t_plan      p;
        logic [7:0] lo;
        logic [7:0] hi;
        logic [2:0] need;
        logic       bad;
        p.kind = K_STOP;
        p.len  = 3'd1;
        lo     = 8'h80;
        hi     = 8'hbf;
        need   = 3'd0;
        bad    = 1'b0;
        if (n == 3'd0) begin
            p.kind = K_STOP;
        end else if (!q0[7]) begin
            if (q0 == CH_QUO || q0 == CH_BSL || q0 == 8'h08 || q0 == 8'h0c ||
                q0 == 8'h0a || q0 == 8'h0d || q0 == 8'h09) begin
                p.kind = K_SHORT;
            end else if (q0 < 8'h20) begin
                p.kind = K_UHEX;
            end else begin
                p.kind = K_PASS;
            end
        end else begin
            if (q0 >= 8'hc2 && q0 <= 8'hdf) begin
                need = 3'd2;
            end else if (q0 == 8'he0) begin
                need = 3'd3;
                lo   = 8'ha0;
            end else if (q0 == 8'hed) begin
                need = 3'd3;
                hi   = 8'h9f;
            end else if (q0 >= 8'he1 && q0 <= 8'hef) begin
                need = 3'd3;
            end else if (q0 == 8'hf0) begin
                need = 3'd4;
                lo   = 8'h90;
            end else if (q0 >= 8'hf1 && q0 <= 8'hf3) begin
                need = 3'd4;
            end else if (q0 == 8'hf4) begin
                need = 3'd4;
                hi   = 8'h8f;
            end else begin
                bad = 1'b1;
            end
            if (!bad) begin
                if (n >= 3'd2 && (q1 < lo || q1 > hi)) begin
                    bad = 1'b1;
                end
                if (need >= 3'd3 && n >= 3'd3 && (q2 < 8'h80 || q2 > 8'hbf)) begin
                    bad = 1'b1;
                end
                if (need == 3'd4 && n >= 3'd4 && (q3 < 8'h80 || q3 > 8'hbf)) begin
                    bad = 1'b1;
                end
            end
            if (bad) begin
                p.kind = K_BAD;
            end else if (n < need) begin
                p.kind = last ? K_BAD : K_STOP;
            end else begin
                p.kind = K_PASS;
                p.len  = need;
            end
        end
        return p;
    endfunction

endpackage

`default_nettype wire

[rtl/jse_datapath.sv]
// Datapath: byte queue, scan decode, escape byte generation, output register.
`default_nettype none

module jse_datapath import jse_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_in  i_in_data,
    input  wire t_cmd i_cmd,
    input  wire logic i_out_ready,
    output t_sts      o_sts,
    output logic      o_out_valid,
    output t_out      o_out_data
);

    logic [7:0] r_q [4];
    logic [2:0] r_n;
    logic       r_last;
    logic [2:0] r_k;
    logic       r_out_valid;
    t_out       r_out_data;

    t_plan      w_plan;
    t_plan      w_look;
    logic [2:0] w_cnt;
    logic [2:0] w_rem;
    logic [7:0] w_sq [4];
    logic [7:0] w_byte;
    logic       w_final;
    logic       w_run_last;

    assign w_plan = f_classify(r_q[0], r_q[1], r_q[2], r_q[3], r_n, r_last);

    always_comb begin
        unique case (w_plan.kind)
            K_PASS:  w_cnt = w_plan.len;
            K_SHORT: w_cnt = 3'd2;
            default: w_cnt = 3'd6;
        endcase
    end

    assign w_final = (r_k == w_cnt - 3'd1);
    assign w_rem   = r_n - w_plan.len;

    // Queue after this action is consumed
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            if (i + int'(w_plan.len) < 4) begin
                w_sq[i] = r_q[2'(i + int'(w_plan.len))];
            end else begin
                w_sq[i] = 8'h00;
            end
        end
    end

    assign w_look = f_classify(w_sq[0], w_sq[1], w_sq[2], w_sq[3], w_rem, r_last);
    assign w_run_last = w_final && (w_look.kind == K_STOP);

    always_comb begin
        w_byte = CH_BSL;
        unique case (w_plan.kind)
            K_PASS: begin
                w_byte = r_q[r_k[1:0]];
            end
            K_SHORT: begin
                w_byte = (r_k == 3'd0) ? CH_BSL : f_short_letter(r_q[0]);
            end
            K_UHEX: begin
                unique case (r_k)
                    3'd0:    w_byte = CH_BSL;
                    3'd1:    w_byte = 8'h75;
                    3'd2:    w_byte = 8'h30;
                    3'd3:    w_byte = 8'h30;
                    3'd4:    w_byte = f_hex(r_q[0][7:4]);
                    default: w_byte = f_hex(r_q[0][3:0]);
                endcase
            end
            default: begin
                unique case (r_k)
                    3'd0:    w_byte = CH_BSL;
                    3'd1:    w_byte = 8'h75;
                    3'd2:    w_byte = 8'h66;
                    3'd3:    w_byte = 8'h66;
                    3'd4:    w_byte = 8'h66;
                    default: w_byte = 8'h64;
                endcase
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n         <= 3'd0;
            r_k         <= 3'd0;
            r_last      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_last <= i_in_data.string_last;
                r_n    <= r_n + 3'd1;
                r_k    <= 3'd0;
            end else if (i_cmd.emit) begin
                if (w_final) begin
                    r_k <= 3'd0;
                    r_n <= w_rem;
                end else begin
                    r_k <= r_k + 3'd1;
                end
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Queue and output payload carry no reset
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_q[r_n[1:0]] <= i_in_data.data_byte;
        end else if (i_cmd.emit && w_final) begin
            for (int i = 0; i < 4; i++) begin
                r_q[i] <= w_sq[i];
            end
        end
        if (i_cmd.emit) begin
            r_out_data.out_byte    <= w_byte;
            r_out_data.run_last    <= w_run_last;
            r_out_data.string_done <= w_run_last && r_last;
        end
    end

    assign o_sts.stop       = (w_plan.kind == K_STOP);
    assign o_sts.final_byte = w_final;
    assign o_sts.look_stop  = (w_look.kind == K_STOP);
    assign o_sts.out_free   = !r_out_valid || i_out_ready;
    assign o_sts.count      = r_n;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

`default_nettype wire

[rtl/jse_ctrl.sv]
// Controller: accepts a request, then steps the datapath through its actions.
`default_nettype none

module jse_ctrl import jse_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    input  wire t_sts i_sts,
    output logic      o_in_ready,
    output t_cmd      o_cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_RUN  = 1'b1;

    logic r_state;
    logic n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd.load = 1'b0;
        o_cmd.emit = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_RUN;
                end
            end
            default: begin
                if (i_sts.stop) begin
                    n_state = S_IDLE;
                end else if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_sts.final_byte && i_sts.look_stop) begin
                        n_state = S_IDLE;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

`default_nettype wire

[rtl/json_string_escape_utf8_sanitize_core.sv]
// Top level: JSON string escaper with strict UTF-8 check, controller plus datapath.
//
//  channel  valid / ready              payload
//  input    i_in_valid / o_in_ready    i_in_data   t_in: data_byte, string_last
//  output   o_out_valid / i_out_ready  o_out_data  t_out: out_byte, run_last, string_done
//
// One request at a time: take it in, then send one output byte per cycle while the
// output is free, for each scan action (plain byte, UTF-8 sequence, escape or
// replacement); a request that sends none (sequence held) returns to idle.
// The output register holds the last byte of a request while the next one is taken;
// output stalls freeze the emit sequencer in place.
// Reset is synchronous, active low; it clears the held byte count and all handshakes.
`default_nettype none

module json_string_escape_utf8_sanitize_core import jse_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_in  i_in_data,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    output t_out      o_out_data
);

    t_cmd w_cmd;   // load a request, emit one output byte
    t_sts w_sts;   // scan decode and output register status

    // Sequencing: idle until a request arrives, then run actions until the scan stops
    jse_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (w_sts),
        .o_in_ready (o_in_ready),
        .o_cmd      (w_cmd)
    );

    // Queue of held bytes plus the new one, decode, and the output stage
    jse_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (w_cmd),
        .i_out_ready (i_out_ready),
        .o_sts       (w_sts),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

    // Never overwrite an output byte that is still waiting
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit |-> w_sts.out_free)
        else $error("emit while output register is occupied");

    // At most three bytes stay held between requests
    a_held_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> (w_sts.count <= 3'd3))
        else $error("held byte count exceeds three");

    // End of string always closes the run of its request
    a_done_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.string_done) |-> o_out_data.run_last)
        else $error("string_done without run_last");

    // A taken request is worked on in the next cycle
    a_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load |=> !o_in_ready)
        else $error("ready right after a load");

endmodule

`default_nettype wire

[dv/json_string_escape_utf8_sanitize_core_tb.sv]
// Self-checking testbench for the JSON string escaper with strict UTF-8 checking.
`timescale 1ns / 100ps

module json_string_escape_utf8_sanitize_core_tb import jse_pkg::*; ();

    // Run limits. The slowest legal run is roughly 100 requests times 24 output
    // bytes, each waiting out the longest receiver stall, plus the long hold-off.
    localparam int unsigned CYCLE_LIMIT   = 500000;
    localparam int unsigned RANDOM_N      = 76;
    localparam int unsigned SQUEEZE_LEN   = 300;
    localparam int unsigned TAIL_CYCLES   = 20;

    // Outcome of looking at a multi-byte sequence from its lead byte.
    typedef enum int {SEQ_BAD, SEQ_OPEN, SEQ_WHOLE} t_seq_verdict;

    // Track what the escaper must produce and check what it does produce.
    class t_escape_tracker;
        t_out        pending_text[$];
        t_out        batch[$];
        logic [7:0]  held[3];
        int unsigned held_n;
        int unsigned faults;
        int unsigned requests;
        int unsigned checked;
        int unsigned strings;
        int unsigned replaced;

        function new();
            held_n   = 0;
            faults   = 0;
            requests = 0;
            checked  = 0;
            strings  = 0;
            replaced = 0;
        endfunction

        function void put(logic [7:0] b);
            t_out o;
            o = '0;
            o.out_byte = b;
            batch.insert(batch.size(), o);
        endfunction

        function void put_str(string s);
            for (int i = 0; i < s.len(); i++) begin
                put(s[i]);
            end
        endfunction

        function void escape_ascii(logic [7:0] b);
            string digits;
            digits = "0123456789abcdef";
            case (b)
                CH_QUO:  put_str("\\\"");
                CH_BSL:  put_str("\\\\");
                8'h08:   put_str("\\b");
                8'h0c:   put_str("\\f");
                8'h0a:   put_str("\\n");
                8'h0d:   put_str("\\r");
                8'h09:   put_str("\\t");
                default: begin
                    if (b < 8'h20) begin
                        put_str("\\u00");
                        put(digits[b[7:4]]);
                        put(digits[b[3:0]]);
                    end else begin
                        put(b);
                    end
                end
            endcase
        endfunction

        // Judge the bytes from q[at] on; the lead byte has its top bit set.
        function t_seq_verdict judge_utf8(logic [7:0] q[4], int at, int avail,
                                          output int len);
            logic [7:0] lead;
            logic [7:0] lo;
            logic [7:0] hi;
            int         need;
            int         upto;
            lead = q[at];
            lo   = 8'h80;
            hi   = 8'hbf;
            len  = 0;
            if (lead >= 8'hc2 && lead <= 8'hdf) begin
                need = 2;
            end else if (lead == 8'he0) begin
                need = 3;
                lo   = 8'ha0;
            end else if (lead == 8'hed) begin
                need = 3;
                hi   = 8'h9f;
            end else if (lead >= 8'he1 && lead <= 8'hef) begin
                need = 3;
            end else if (lead == 8'hf0) begin
                need = 4;
                lo   = 8'h90;
            end else if (lead >= 8'hf1 && lead <= 8'hf3) begin
                need = 4;
            end else if (lead == 8'hf4) begin
                need = 4;
                hi   = 8'h8f;
            end else begin
                return SEQ_BAD;
            end
            upto = (avail < need) ? avail : need;
            for (int k = 1; k < upto; k++) begin
                if (k == 1 && (q[at + k] < lo || q[at + k] > hi)) begin
                    return SEQ_BAD;
                end
                if (k > 1 && (q[at + k] < 8'h80 || q[at + k] > 8'hbf)) begin
                    return SEQ_BAD;
                end
            end
            if (avail < need) begin
                return SEQ_OPEN;
            end
            len = need;
            return SEQ_WHOLE;
        endfunction

        // Work out every output byte that one accepted request causes.
        function void note_byte(t_in item);
            logic [7:0]   q[4];
            int           n;
            int           pos;
            int           len;
            t_seq_verdict v;
            n   = 0;
            pos = 0;
            q   = '{default: 8'h00};
            batch.delete();
            requests++;
            for (int i = 0; i < held_n; i++) begin
                q[n] = held[i];
                n++;
            end
            q[n] = item.data_byte;
            n++;
            while (pos < n) begin
                if (!q[pos][7]) begin
                    escape_ascii(q[pos]);
                    pos++;
                end else begin
                    v = judge_utf8(q, pos, n - pos, len);
                    if (v == SEQ_WHOLE) begin
                        for (int i = 0; i < len; i++) begin
                            put(q[pos + i]);
                        end
                        pos += len;
                    end else if (v == SEQ_BAD || item.string_last) begin
                        // replace the lead byte only, rescan what follows it
                        put_str("\\ufffd");
                        replaced++;
                        pos++;
                    end else begin
                        break;
                    end
                end
            end
            held_n = n - pos;
            for (int i = 0; i < held_n; i++) begin
                held[i] = q[pos + i];
            end
            if (batch.size() > 0) begin
                batch[batch.size() - 1].run_last    = 1'b1;
                batch[batch.size() - 1].string_done = item.string_last;
            end
            if (item.string_last) begin
                strings++;
            end
            foreach (batch[i]) begin
                pending_text.insert(pending_text.size(), batch[i]);
            end
        endfunction

        function void check_out(t_out got);
            t_out want;
            if (pending_text.size() == 0) begin
                faults++;
                $display("%0t: output byte %h with nothing expected", $time, got.out_byte);
                return;
            end
            want = pending_text.pop_front();
            checked++;
            if (got.out_byte !== want.out_byte) begin
                faults++;
                $display("%0t: out_byte expected %h actual %h", $time,
                         want.out_byte, got.out_byte);
            end
            if (got.run_last !== want.run_last) begin
                faults++;
                $display("%0t: run_last expected %b actual %b (byte %h)", $time,
                         want.run_last, got.run_last, want.out_byte);
            end
            if (got.string_done !== want.string_done) begin
                faults++;
                $display("%0t: string_done expected %b actual %b (byte %h)", $time,
                         want.string_done, got.string_done, want.out_byte);
            end
        endfunction
    endclass

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_in_valid  = 1'b0;
    t_in  i_in_data   = '0;
    logic i_out_ready = 1'b0;
    logic o_in_ready;
    logic o_out_valid;
    t_out o_out_data;

    t_escape_tracker tracker = new();

    int unsigned sent       = 0;
    bit          steady_tx  = 1'b0;  // no sender gaps while set
    bit          squeeze_go = 1'b0;  // ask the receiver for its long hold-off

    // Opening requests, {string_last, data_byte}: every short escape, the
    // ASCII extremes, valid sequences at the range edges, a stray continuation,
    // a bad byte inside a sequence, a surrogate, a bad lead and a sequence cut
    // short by the end of the string.
    logic [8:0] opening[24] = '{
        9'h000, 9'h01f, 9'h022, 9'h05c, 9'h008, 9'h00c, 9'h00a, 9'h00d,
        9'h009, 9'h07f,
        9'h0c2, 9'h080,                  // smallest two-byte form
        9'h0e0, 9'h080,                  // overlong three-byte, then stray
        9'h0ed, 9'h0a0,                  // surrogate
        9'h0f4, 9'h08f, 9'h0bf, 9'h0bf,  // U+10FFFF
        9'h0ff,                          // never a lead
        9'h0f0, 9'h090, 9'h180           // truncated at end of string
    };

    json_string_escape_utf8_sanitize_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Idle length: mostly none or short, now and then long.
    function automatic int unsigned pick_idle();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 88) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 40);
    endfunction

    function automatic logic rand_last();
        return ($urandom_range(0, 11) == 0);
    endfunction

    // Offer one request, hold it until taken, note it, then maybe go idle.
    task automatic send_byte(input logic [7:0] b, input logic last);
        t_in         item;
        int unsigned idle;
        item.data_byte   = b;
        item.string_last = last;
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
        tracker.note_byte(item);
        sent++;
        idle = steady_tx ? 0 : pick_idle();
        if (idle > 0) begin
            i_in_valid <= 1'b0;
            repeat (idle) @(posedge i_clk);
        end
    endtask

    // Send a well-formed sequence of the given length, or only a prefix of it.
    task automatic send_utf8(input int len, input bit cut);
        logic [7:0] seq[4];
        logic [7:0] lo;
        logic [7:0] hi;
        int         count;
        lo = 8'h80;
        hi = 8'hbf;
        if (len == 2) begin
            seq[0] = 8'($urandom_range(8'hc2, 8'hdf));
        end else if (len == 3) begin
            seq[0] = 8'($urandom_range(8'he0, 8'hef));
            if (seq[0] == 8'he0) lo = 8'ha0;
            if (seq[0] == 8'hed) hi = 8'h9f;
        end else begin
            seq[0] = 8'($urandom_range(8'hf0, 8'hf4));
            if (seq[0] == 8'hf0) lo = 8'h90;
            if (seq[0] == 8'hf4) hi = 8'h8f;
        end
        seq[1] = 8'($urandom_range(lo, hi));
        seq[2] = 8'($urandom_range(8'h80, 8'hbf));
        seq[3] = 8'($urandom_range(8'h80, 8'hbf));
        count  = cut ? int'($urandom_range(1, len - 1)) : len;
        for (int i = 0; i < count; i++) begin
            send_byte(seq[i], (i == count - 1) ? rand_last() : 1'b0);
        end
    endtask

    // Check every output byte taken by the receiver.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            tracker.check_out(o_out_data);
        end
    end

    // Receiver: random stalls, a recurring quiet window without stalls, and one long
    // hold-off so the block backs up and stalls its input side.
    initial begin
        int unsigned stall;
        int unsigned rx_cycles;
        bit          squeezed;
        rx_cycles = 0;
        squeezed  = 1'b0;
        forever begin
            @(posedge i_clk);
            rx_cycles++;
            if (squeeze_go && !squeezed) begin
                squeezed = 1'b1;
                i_out_ready <= 1'b0;
                repeat (SQUEEZE_LEN) @(posedge i_clk);
                rx_cycles += SQUEEZE_LEN;
                i_out_ready <= 1'b1;
            end else begin
                stall = ((rx_cycles % 400) < 100 || $urandom_range(0, 3) != 0) ? 0 :
                        pick_idle();
                if (stall > 0) begin
                    i_out_ready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                    rx_cycles += stall;
                end
                i_out_ready <= 1'b1;
            end
        end
    end

    // Watchdog.
    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        int unsigned pick;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (opening[i]) begin
            send_byte(opening[i][7:0], opening[i][8]);
        end

        // Random part: mostly well-formed text with random content, the rest
        // truncated sequences and raw noise. Every third block of 16 requests
        // runs without sender gaps.
        while (sent < $size(opening) + RANDOM_N) begin
            steady_tx = (((sent / 16) % 3) == 1);
            if (sent >= $size(opening) + 30) begin
                squeeze_go = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                send_byte(8'($urandom_range(0, 127)), rand_last());
            end else if (pick < 75) begin
                send_utf8($urandom_range(2, 4), 1'b0);
            end else if (pick < 88) begin
                send_utf8($urandom_range(2, 4), 1'b1);
            end else begin
                send_byte(8'($urandom_range(0, 255)), rand_last());
            end
        end
        i_in_valid <= 1'b0;

        // Drain, then give the block time to show any stray output.
        while (tracker.pending_text.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Sent %0d requests in %0d strings; checked %0d output bytes,",
                 tracker.requests, tracker.strings, tracker.checked);
        $display("including %0d replacement escapes, under random stalls and one long hold-off.",
                 tracker.replaced);
        if (tracker.faults == 0 && tracker.pending_text.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
